[hw/rtl/byte_cpu_instruction_step_core_defines.svh]
// Assertion shorthands, clocked on clk and disabled while rst_n is low.
`ifndef BYTE_CPU_INSTRUCTION_STEP_CORE_DEFINES_SVH
`define BYTE_CPU_INSTRUCTION_STEP_CORE_DEFINES_SVH

// same-cycle implication
`define BCPU_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BCPU_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bcpu_pkg.sv]
`timescale 1ns / 1ps

package bcpu_pkg;

    localparam int BYTE_W    = 8;
    localparam int ADDR_SPAN = 1 << BYTE_W;
    localparam int MEM_DEPTH = 256;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int REG_COUNT = 16;
    localparam int RF_AW     = $clog2(REG_COUNT);
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 64;

    typedef logic [MEM_AW-1:0] maddr_t;
    typedef logic [RF_AW-1:0]  raddr_t;
    typedef maddr_t mod_tbl_t [ADDR_SPAN];

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_STEP  = 2'd1,
        KIND_RDREG = 2'd2,
        KIND_RDMEM = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        OP_LOAD  = 4'h1,
        OP_LDI   = 4'h2,
        OP_STORE = 4'h3,
        OP_MOVE  = 4'h4,
        OP_ADD   = 4'h5,
        OP_ADD2  = 4'h6,
        OP_OR    = 4'h7,
        OP_AND   = 4'h8,
        OP_XOR   = 4'h9,
        OP_ROR   = 4'hA,
        OP_JMP   = 4'hB,
        OP_HALT  = 4'hC
    } op_t;

    // first member sits in the top bits, so pc_now lands at bit 0 of tdata
    typedef struct packed {
        logic [7:0]  peek_data;
        logic [7:0]  mem_wr_value;
        logic [7:0]  mem_wr_addr;
        logic        mem_wrote;
        logic [7:0]  reg_wr_value;
        logic [3:0]  reg_wr_index;
        logic        reg_wrote;
        logic [15:0] instr_word;
        logic        bad_opcode;
        logic        is_halted;
        logic [7:0]  pc_now;
    } res_t;

    typedef struct packed {
        logic capture;
        logic dispatch;
        logic fetch_lo;
        logic decode;
        logic exec;
        logic peek;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  halted;
    } stat_t;

    function automatic mod_tbl_t build_mod_tbl();
        mod_tbl_t tbl;
        for (int i = 0; i < ADDR_SPAN; i++)
        begin
            tbl[i] = MEM_AW'(i % MEM_DEPTH);
        end
        return tbl;
    endfunction

    localparam mod_tbl_t MOD_TBL = build_mod_tbl();

    function automatic maddr_t mem_index(input logic [BYTE_W-1:0] a);
        return MOD_TBL[a];
    endfunction

endpackage

[hw/rtl/bcpu_ctrl.sv]
`timescale 1ns / 1ps
`include "byte_cpu_instruction_step_core_defines.svh"

module bcpu_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  bcpu_pkg::stat_t stat,
    output bcpu_pkg::cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_DISPATCH = 7'b0000010,
        ST_FETCH_LO = 7'b0000100,
        ST_DECODE   = 7'b0001000,
        ST_EXEC     = 7'b0010000,
        ST_PEEK     = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_vld_reg, out_vld_next;
    logic   out_free;

    assign out_free = !out_vld_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_vld_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.capture  = (state_reg == ST_IDLE) && s_tvalid;
        cmd.dispatch = (state_reg == ST_DISPATCH);
        cmd.fetch_lo = (state_reg == ST_FETCH_LO);
        cmd.decode   = (state_reg == ST_DECODE);
        cmd.exec     = (state_reg == ST_EXEC);
        cmd.peek     = (state_reg == ST_PEEK);
        cmd.load_out = (state_reg == ST_DONE) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                priority if (stat.kind == bcpu_pkg::KIND_STEP && !stat.halted)
                    state_next = ST_FETCH_LO;
                else if (stat.kind == bcpu_pkg::KIND_RDREG || stat.kind == bcpu_pkg::KIND_RDMEM)
                    state_next = ST_PEEK;
                else
                    state_next = ST_DONE;
            end
            ST_FETCH_LO: state_next = ST_DECODE;
            ST_DECODE:   state_next = ST_EXEC;
            ST_EXEC:     state_next = ST_DONE;
            ST_PEEK:     state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (cmd.load_out)
            out_vld_next = 1'b1;
        else if (m_tready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    `BCPU_ASSERT_NEXT(a_capture_dispatch, cmd.capture, state_reg == ST_DISPATCH, "item accepted but no dispatch")
    `BCPU_ASSERT_NEXT(a_load_out_valid, cmd.load_out, m_tvalid, "result loaded but not offered")
    `BCPU_ASSERT_NEXT(a_step_fetch, cmd.dispatch && stat.kind == bcpu_pkg::KIND_STEP && !stat.halted, state_reg == ST_FETCH_LO, "live step skipped fetch")

endmodule

[hw/rtl/bcpu_dpath.sv]
`timescale 1ns / 1ps
`include "byte_cpu_instruction_step_core_defines.svh"

module bcpu_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bcpu_pkg::cmd_t                     cmd,
    output bcpu_pkg::stat_t                    stat,
    input  logic [bcpu_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [1:0]                         s_tuser,
    output logic [bcpu_pkg::OUT_DATA_W-1:0]    m_tdata
);

    // captured item
    bcpu_pkg::kind_t kind_reg;
    logic [7:0]      maddr_reg;
    logic [7:0]      lbyte_reg;
    logic [3:0]      rsel_reg;

    // architectural state
    logic [7:0]  pc_reg, pc_next;
    logic        halted_reg, halted_next;

    logic [7:0]  hi_reg;
    logic [15:0] word_reg;
    logic [15:0] word_now;

    // main memory, single port, registered read
    logic [7:0]                       mem_ram [bcpu_pkg::MEM_DEPTH];
    logic [bcpu_pkg::MEM_DEPTH-1:0]   mem_vld_reg;
    logic [7:0]                       mem_rd_reg;
    logic                             mem_rd_vld_reg;
    logic                             mem_we, mem_re;
    bcpu_pkg::maddr_t                 mem_addr;
    logic [7:0]                       mem_wdata;
    logic [7:0]                       mem_byte;

    // register file, two read ports, one write port
    logic [7:0]                       rf_ram [bcpu_pkg::REG_COUNT];
    logic [bcpu_pkg::REG_COUNT-1:0]   rf_vld_reg;
    logic [7:0]                       rf_a_reg, rf_b_reg;
    logic                             rf_a_vld_reg, rf_b_vld_reg;
    logic                             rf_re;
    bcpu_pkg::raddr_t                 rf_a_addr, rf_b_addr;
    logic [7:0]                       rfa, rfb;

    // execute
    logic [3:0]  dec_op;
    logic [3:0]  ex_op, ex_r, ex_s, ex_t;
    logic [7:0]  ex_st;
    logic        ex_wr, ex_mw, ex_bad, ex_halt, ex_jump;
    logic [3:0]  ex_widx;
    logic [7:0]  ex_wval;
    logic [15:0] rot_w;

    bcpu_pkg::res_t res_reg, res_next;
    bcpu_pkg::res_t out_reg;

    assign stat.kind   = kind_reg;
    assign stat.halted = halted_reg;
    assign m_tdata     = out_reg;

    assign mem_byte = mem_rd_vld_reg ? mem_rd_reg : 8'h00;
    assign rfa      = rf_a_vld_reg ? rf_a_reg : 8'h00;
    assign rfb      = rf_b_vld_reg ? rf_b_reg : 8'h00;
    assign word_now = {hi_reg, mem_byte};
    assign dec_op   = word_now[15:12];

    assign ex_op = word_reg[15:12];
    assign ex_r  = word_reg[11:8];
    assign ex_s  = word_reg[7:4];
    assign ex_t  = word_reg[3:0];
    assign ex_st = word_reg[7:0];
    assign rot_w = {rfa, rfa} >> ex_t[2:0];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= bcpu_pkg::kind_t'(s_tuser);
            maddr_reg <= s_tdata[7:0];
            lbyte_reg <= s_tdata[15:8];
            rsel_reg  <= s_tdata[19:16];
        end
        if (cmd.fetch_lo)
            hi_reg <= mem_byte;
        if (cmd.decode)
            word_reg <= word_now;
    end

    // memory port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = bcpu_pkg::mem_index(pc_reg);
        mem_wdata = lbyte_reg;
        if (cmd.dispatch)
        begin
            unique case (kind_reg)
                bcpu_pkg::KIND_LOAD:
                begin
                    mem_we   = 1'b1;
                    mem_addr = bcpu_pkg::mem_index(maddr_reg);
                end
                bcpu_pkg::KIND_RDMEM:
                begin
                    mem_re   = 1'b1;
                    mem_addr = bcpu_pkg::mem_index(maddr_reg);
                end
                bcpu_pkg::KIND_STEP:
                begin
                    mem_re   = 1'b1;
                    mem_addr = bcpu_pkg::mem_index(pc_reg);
                end
                bcpu_pkg::KIND_RDREG:
                begin
                    mem_re   = 1'b0;
                end
            endcase
        end
        else if (cmd.fetch_lo)
        begin
            mem_re   = 1'b1;
            mem_addr = bcpu_pkg::mem_index(pc_reg + 8'd1);
        end
        else if (cmd.decode)
        begin
            mem_re   = 1'b1;
            mem_addr = bcpu_pkg::mem_index(word_now[7:0]);
        end
        else if (cmd.exec && ex_op == bcpu_pkg::OP_STORE)
        begin
            mem_we    = 1'b1;
            mem_addr  = bcpu_pkg::mem_index(ex_st);
            mem_wdata = rfa;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem_ram[mem_addr] <= mem_wdata;
        if (mem_re)
            mem_rd_reg <= mem_ram[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_vld_reg    <= '0;
            mem_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
                mem_vld_reg[mem_addr] <= 1'b1;
            if (mem_re)
                mem_rd_vld_reg <= mem_vld_reg[mem_addr];
        end
    end

    // register file read addresses
    always_comb
    begin
        rf_re     = 1'b0;
        rf_a_addr = rsel_reg;
        rf_b_addr = word_now[3:0];
        if (cmd.dispatch && kind_reg == bcpu_pkg::KIND_RDREG)
        begin
            rf_re     = 1'b1;
            rf_a_addr = rsel_reg;
        end
        else if (cmd.decode)
        begin
            rf_re = 1'b1;
            if (dec_op >= bcpu_pkg::OP_MOVE && dec_op <= bcpu_pkg::OP_XOR)
                rf_a_addr = word_now[7:4];
            else
                rf_a_addr = word_now[11:8];
            if (dec_op == bcpu_pkg::OP_JMP)
                rf_b_addr = '0;
            else
                rf_b_addr = word_now[3:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && ex_wr)
            rf_ram[ex_widx] <= ex_wval;
        if (rf_re)
        begin
            rf_a_reg <= rf_ram[rf_a_addr];
            rf_b_reg <= rf_ram[rf_b_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_vld_reg   <= '0;
            rf_a_vld_reg <= 1'b0;
            rf_b_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec && ex_wr)
                rf_vld_reg[ex_widx] <= 1'b1;
            if (rf_re)
            begin
                rf_a_vld_reg <= rf_vld_reg[rf_a_addr];
                rf_b_vld_reg <= rf_vld_reg[rf_b_addr];
            end
        end
    end

    // execute
    always_comb
    begin
        ex_wr   = 1'b0;
        ex_mw   = 1'b0;
        ex_bad  = 1'b0;
        ex_halt = 1'b0;
        ex_jump = 1'b0;
        ex_widx = ex_r;
        ex_wval = 8'h00;
        unique case (bcpu_pkg::op_t'(ex_op))
            bcpu_pkg::OP_LOAD:
            begin
                ex_wr   = 1'b1;
                ex_wval = mem_byte;
            end
            bcpu_pkg::OP_LDI:
            begin
                ex_wr   = 1'b1;
                ex_wval = ex_st;
            end
            bcpu_pkg::OP_STORE: ex_mw = 1'b1;
            bcpu_pkg::OP_MOVE:
            begin
                ex_wr   = 1'b1;
                ex_widx = ex_t;
                ex_wval = rfa;
            end
            bcpu_pkg::OP_ADD, bcpu_pkg::OP_ADD2:
            begin
                ex_wr   = 1'b1;
                ex_wval = rfa + rfb;
            end
            bcpu_pkg::OP_OR:
            begin
                ex_wr   = 1'b1;
                ex_wval = rfa | rfb;
            end
            bcpu_pkg::OP_AND:
            begin
                ex_wr   = 1'b1;
                ex_wval = rfa & rfb;
            end
            bcpu_pkg::OP_XOR:
            begin
                ex_wr   = 1'b1;
                ex_wval = rfa ^ rfb;
            end
            bcpu_pkg::OP_ROR:
            begin
                ex_wr   = 1'b1;
                ex_wval = rot_w[7:0];
            end
            bcpu_pkg::OP_JMP:  ex_jump = (rfa == rfb);
            bcpu_pkg::OP_HALT: ex_halt = 1'b1;
            default:
            begin
                ex_halt = 1'b1;
                ex_bad  = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        pc_next     = pc_reg;
        halted_next = halted_reg;
        if (cmd.exec)
        begin
            pc_next     = ex_jump ? ex_st : pc_reg + 8'd2;
            halted_next = halted_reg || ex_halt;
        end
    end

    always_comb
    begin
        res_next           = res_reg;
        if (cmd.dispatch || cmd.peek || cmd.exec)
        begin
            res_next           = '0;
            res_next.pc_now    = pc_next;
            res_next.is_halted = halted_next;
        end
        if (cmd.peek)
            res_next.peek_data = (kind_reg == bcpu_pkg::KIND_RDREG) ? rfa : mem_byte;
        if (cmd.exec)
        begin
            res_next.instr_word   = word_reg;
            res_next.bad_opcode   = ex_bad;
            res_next.reg_wrote    = ex_wr;
            res_next.reg_wr_index = ex_wr ? ex_widx : 4'h0;
            res_next.reg_wr_value = ex_wr ? ex_wval : 8'h00;
            res_next.mem_wrote    = ex_mw;
            res_next.mem_wr_addr  = ex_mw ? ex_st : 8'h00;
            res_next.mem_wr_value = ex_mw ? rfa : 8'h00;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (cmd.load_out)
            out_reg <= res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= 8'h00;
            halted_reg <= 1'b0;
        end
        else
        begin
            pc_reg     <= pc_next;
            halted_reg <= halted_next;
        end
    end

    `BCPU_ASSERT_NEXT(a_halt_sticky, halted_reg, halted_reg, "halted flag cleared without reset")
    `BCPU_ASSERT_NEXT(a_pc_only_exec, !cmd.exec, $stable(pc_reg), "pc moved outside execute")

endmodule

[hw/rtl/byte_cpu_instruction_step_core.sv]
`timescale 1ns / 1ps
// channel   direction  handshake           payload
// s_*       in         s_tvalid/s_tready   s_tdata (mem_addr, load_byte, reg_select), s_tuser (kind)
// m_*       out        m_tvalid/m_tready   m_tdata (one result item per input item)
// Path: load, and a step while halted, pass dispatch to done; a register or memory read adds peek;
// a step adds fetch_lo, decode, exec (single-port memory: two fetch reads, operand read or store).
// Reset: asynchronous; memory and register file read as zero through valid bits cleared
// at once, no clearing pass.
// Stalls: a finished item waits in the output register; the next item is taken meanwhile,
// and its result waits in the done state until the output register is free.

module byte_cpu_instruction_step_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] mem_addr, [15:8] load_byte, [19:16] reg_select
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [7:0] pc_now, [8] is_halted, [9] bad_opcode,
                                   // [25:10] instr_word, [26] reg_wrote, [30:27] reg_wr_index,
                                   // [38:31] reg_wr_value, [39] mem_wrote, [47:40] mem_wr_addr,
                                   // [55:48] mem_wr_value, [63:56] peek_data
);

    bcpu_pkg::cmd_t  cmd;
    bcpu_pkg::stat_t stat;

    bcpu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bcpu_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata)
    );

endmodule
